// ===== design/boid_steering_integrator_assert.svh =====
// Assertion macros for the steering integrator.
// Used by boid_steering_integrator.sv; expects clk and rst_n in scope.
`ifndef BOID_STEERING_INTEGRATOR_ASSERT_SVH
`define BOID_STEERING_INTEGRATOR_ASSERT_SVH
`ifndef SYNTHESIS
// pre holds -> post holds in the same cycle
`define BSI_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("steering integrator assertion failed");
// pre holds -> post holds in the next cycle
`define BSI_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("steering integrator assertion failed");
`else
`define BSI_ASSERT_NOW(label, pre, post)
`define BSI_ASSERT_NEXT(label, pre, post)
`endif
`endif

// ===== design/bsi_pkg.sv =====
// Shared types, constants and helpers for the steering integrator.
// No dependencies; imported by every module of the block.
package bsi_pkg;

    localparam int FRAC_BITS = 16;
    localparam logic [63:0] DEAD_ZONE_SQ = 64'd1;
    localparam int CFG_IDX_W = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_FORCE = 2'd1;

    localparam logic [30:0] MAX_SPEED_RST = 31'd262144;
    localparam logic [30:0] MAX_FORCE_RST = 31'd6554;

    // Opcodes
    localparam logic [2:0] OP_UPDATE   = 3'd0;
    localparam logic [2:0] OP_SEEK     = 3'd1;
    localparam logic [2:0] OP_SEEK_OUT = 3'd2;
    localparam logic [2:0] OP_ARRIVE   = 3'd3;
    localparam logic [2:0] OP_FLEE     = 3'd4;

    localparam logic [30:0] ONE_FIX = 31'd1 << FRAC_BITS;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
        logic [30:0]        reach;
        logic signed [31:0] gain;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [31:0] steer_x;
        logic signed [31:0] steer_y;
        logic signed [31:0] steer_z;
    } result_t;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic [63:0] quot;
    } div_rsp_t;

    typedef struct packed {
        logic        start;
        logic [63:0] radicand;
    } sqrt_req_t;

    typedef struct packed {
        logic        busy;
        logic [31:0] root;
    } sqrt_rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UPD_SUM,
        S_SQ,
        S_CHECK,
        S_SQRT_GO,
        S_SQRT_WAIT,
        S_SC_MUL,
        S_SC_GO,
        S_SC_WAIT,
        S_SUBV,
        S_G_MUL,
        S_G_WR,
        S_ACC,
        S_UPD_END,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        PH_DIST,
        PH_FORCE,
        PH_SPEED
    } phase_t;

    // Saturate a 33-bit sum to 32 bits
    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31])
            r = v[32] ? S32_MIN : S32_MAX;
        else
            r = v[31:0];
        return r;
    endfunction

    // Magnitude of a signed 32-bit value; -2^31 gives 2^31
    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        logic [31:0] r;
        r = v[31] ? (~v + 32'd1) : v;
        return r;
    endfunction

endpackage

// ===== design/boid_steering_integrator.sv =====
// Top level of the steering integrator: sequencer, state and shared multiplier.
// Depends on bsi_pkg, bsi_div, bsi_sqrt and boid_steering_integrator_assert.svh.
//
// Usage:
// - Command channel (in_valid/in_ready/in_data) takes one command per transaction;
//   in_ready is high only while the sequencer is idle.
// - Result channel (out_valid/out_ready/out_data) returns one result per command:
//   position and velocity after the command and the steering force it added.
// - Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes max_speed
//   (index 0) or max_force (index 1); cfg_ready is always high, other indexes
//   are dropped. Write only while no command is in flight.
// - Processing time depends on the path: an unknown opcode, a skipped command,
//   an update with or without the speed clamp and a full steering command all
//   differ. The cost is set by one divider run per vector component for each
//   length normalization plus one run of the square root unit per square root.
// - One command at a time; the next is taken once the result sits in the
//   output register, so a stalled receiver holds the block only when that
//   register is still full at the end of the following command.
// - Reset clears position, velocity, acceleration and the output valid, and
//   loads max_speed = 4.0 and max_force of about 0.1.
`include "boid_steering_integrator_assert.svh"

module boid_steering_integrator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  bsi_pkg::cmd_t                     in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output bsi_pkg::result_t                  out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bsi_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [30:0]                       cfg_data
);
    import bsi_pkg::*;

    // Control and agent state
    state_t             state_reg, state_next;
    phase_t             phase_reg, phase_next;
    logic [2:0]         cnt_reg, cnt_next;
    logic signed [31:0] pos_reg [3];
    logic signed [31:0] pos_next [3];
    logic signed [31:0] vel_reg [3];
    logic signed [31:0] vel_next [3];
    logic signed [31:0] acc_reg [3];
    logic signed [31:0] acc_next [3];
    logic [30:0]        ms_reg, ms_next;
    logic [30:0]        mf_reg, mf_next;
    logic               out_valid_reg, out_valid_next;

    // Working registers
    logic [2:0]         op_reg, op_next;
    logic [30:0]        reach_reg, reach_next;
    logic signed [31:0] gain_reg, gain_next;
    logic signed [31:0] d_reg [3];
    logic signed [31:0] d_next [3];
    logic signed [31:0] s_reg [3];
    logic signed [31:0] s_next [3];
    logic [63:0]        sum_reg, sum_next;
    logic [61:0]        lim_reg, lim_next;
    logic [63:0]        prod_reg, prod_next;
    logic [31:0]        den_reg, den_next;
    result_t            out_reg, out_next;

    // Shared units
    div_req_t           div_req;
    div_rsp_t           div_rsp;
    sqrt_req_t          sqrt_req;
    sqrt_rsp_t          sqrt_rsp;

    // Combinational helpers
    logic signed [31:0] d_elem, s_elem, vec_elem;
    logic [30:0]        sqx;
    logic [31:0]        mul_a, mul_b;
    logic signed [31:0] tgt [3];
    logic signed [31:0] scaled;
    logic [63:0]        gain_t;
    logic signed [31:0] gained;
    logic               gsgn;

    bsi_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    bsi_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sqrt_req),
        .rsp   (sqrt_rsp)
    );

    assign tgt[0] = in_data.target_x;
    assign tgt[1] = in_data.target_y;
    assign tgt[2] = in_data.target_z;

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_DIST;
            cnt_reg       <= '0;
            ms_reg        <= MAX_SPEED_RST;
            mf_reg        <= MAX_FORCE_RST;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i] <= '0;
                vel_reg[i] <= '0;
                acc_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            ms_reg        <= ms_next;
            mf_reg        <= mf_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i] <= pos_next[i];
                vel_reg[i] <= vel_next[i];
                acc_reg[i] <= acc_next[i];
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        reach_reg <= reach_next;
        gain_reg  <= gain_next;
        sum_reg   <= sum_next;
        lim_reg   <= lim_next;
        prod_reg  <= prod_next;
        den_reg   <= den_next;
        out_reg   <= out_next;
        for (int i = 0; i < 3; i++)
        begin
            d_reg[i] <= d_next[i];
            s_reg[i] <= s_next[i];
        end
    end

    // Element select by the loop counter
    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:
            begin
                d_elem = d_reg[0];
                s_elem = s_reg[0];
            end
            2'd1:
            begin
                d_elem = d_reg[1];
                s_elem = s_reg[1];
            end
            default:
            begin
                d_elem = d_reg[2];
                s_elem = s_reg[2];
            end
        endcase
        vec_elem = (state_reg == S_SQ && phase_reg == PH_DIST) ? d_elem : s_elem;
    end

    // Shared multiplier operands
    always_comb
    begin
        unique case (phase_reg)
            PH_DIST:  sqx = reach_reg;
            PH_FORCE: sqx = mf_reg;
            default:  sqx = ms_reg;
        endcase
        mul_a = mag32(vec_elem);
        mul_b = mag32(vec_elem);
        if (state_reg == S_SQ && cnt_reg == 3'd3)
        begin
            mul_a = {1'b0, sqx};
            mul_b = {1'b0, sqx};
        end
        else if (state_reg == S_SC_MUL)
            mul_b = {1'b0, (phase_reg == PH_FORCE) ? mf_reg : ms_reg};
        else if (state_reg == S_G_MUL)
            mul_b = mag32(gain_reg);
        prod_next = 64'(mul_a) * 64'(mul_b);
    end

    // Divider result: sign restored, saturated
    always_comb
    begin
        if (den_reg == '0)
            scaled = '0;
        else if (|div_rsp.quot[63:31])
            scaled = s_elem[31] ? S32_MIN : S32_MAX;
        else if (s_elem[31])
            scaled = 32'sd0 - signed'(div_rsp.quot[31:0]);
        else
            scaled = signed'(div_rsp.quot[31:0]);
    end

    // Gain product: truncate toward zero, saturate, invert for flee
    always_comb
    begin
        gain_t = prod_reg >> FRAC_BITS;
        gsgn   = s_elem[31] ^ gain_reg[31];
        if (|gain_t[63:31])
            gained = gsgn ? S32_MIN : S32_MAX;
        else if (gsgn)
            gained = 32'sd0 - signed'(gain_t[31:0]);
        else
            gained = signed'(gain_t[31:0]);
        if (op_reg == OP_FLEE)
            gained = (gained == S32_MIN) ? S32_MAX : (32'sd0 - gained);
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        ms_next        = ms_reg;
        mf_next        = mf_reg;
        op_next        = op_reg;
        reach_next     = reach_reg;
        gain_next      = gain_reg;
        sum_next       = sum_reg;
        lim_next       = lim_reg;
        den_next       = den_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        for (int i = 0; i < 3; i++)
        begin
            pos_next[i] = pos_reg[i];
            vel_next[i] = vel_reg[i];
            acc_next[i] = acc_reg[i];
            d_next[i]   = d_reg[i];
            s_next[i]   = s_reg[i];
        end

        // Configuration writes
        if (cfg_valid)
        begin
            if (cfg_index == REG_MAX_SPEED)
                ms_next = cfg_data;
            else if (cfg_index == REG_MAX_FORCE)
                mf_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = in_data.opcode;
                    reach_next = in_data.reach;
                    gain_next  = in_data.gain;
                    for (int i = 0; i < 3; i++)
                        d_next[i] = sat33(33'(tgt[i]) - 33'(pos_reg[i]));
                    sum_next = '0;
                    cnt_next = '0;
                    if (in_data.opcode == OP_UPDATE)
                        state_next = S_UPD_SUM;
                    else if (in_data.opcode <= OP_FLEE)
                    begin
                        phase_next = PH_DIST;
                        state_next = S_SQ;
                    end
                    else
                    begin
                        for (int i = 0; i < 3; i++)
                            s_next[i] = '0;
                        state_next = S_OUT;
                    end
                end
            end

            S_UPD_SUM:
            begin
                for (int i = 0; i < 3; i++)
                    s_next[i] = sat33(33'(vel_reg[i]) + 33'(acc_reg[i]));
                phase_next = PH_SPEED;
                sum_next   = '0;
                cnt_next   = '0;
                state_next = S_SQ;
            end

            // Three squares into sum, then the limit square
            S_SQ:
            begin
                if (cnt_reg != 3'd0 && cnt_reg != 3'd4)
                    sum_next = sum_reg + prod_reg;
                if (cnt_reg == 3'd4)
                begin
                    lim_next   = prod_reg[61:0];
                    state_next = S_CHECK;
                end
                else
                    cnt_next = cnt_reg + 3'd1;
            end

            S_CHECK:
            begin
                cnt_next = '0;
                unique case (phase_reg)
                    PH_DIST:
                    begin
                        if ((op_reg == OP_SEEK_OUT && sum_reg < {2'b00, lim_reg}) ||
                            (op_reg == OP_FLEE && sum_reg > {2'b00, lim_reg}))
                        begin
                            for (int i = 0; i < 3; i++)
                                s_next[i] = '0;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            for (int i = 0; i < 3; i++)
                                s_next[i] = d_reg[i];
                            if (sum_reg <= DEAD_ZONE_SQ)
                                state_next = S_G_MUL;
                            else if ((op_reg == OP_ARRIVE || op_reg == OP_FLEE) &&
                                     reach_reg > ONE_FIX && sum_reg < {2'b00, lim_reg})
                            begin
                                den_next   = {1'b0, reach_reg};
                                state_next = S_SC_MUL;
                            end
                            else
                                state_next = S_SQRT_GO;
                        end
                    end
                    PH_FORCE:
                    begin
                        if (sum_reg > {2'b00, lim_reg})
                            state_next = S_SQRT_GO;
                        else
                            state_next = S_G_MUL;
                    end
                    default:
                    begin
                        if (sum_reg >= {2'b00, lim_reg})
                            state_next = S_SQRT_GO;
                        else
                            state_next = S_UPD_END;
                    end
                endcase
            end

            S_SQRT_GO:
                state_next = S_SQRT_WAIT;

            S_SQRT_WAIT:
            begin
                if (!sqrt_rsp.busy)
                begin
                    den_next   = sqrt_rsp.root;
                    cnt_next   = '0;
                    state_next = S_SC_MUL;
                end
            end

            S_SC_MUL:
                state_next = S_SC_GO;

            S_SC_GO:
                state_next = S_SC_WAIT;

            S_SC_WAIT:
            begin
                if (!div_rsp.busy)
                begin
                    s_next[cnt_reg[1:0]] = scaled;
                    if (cnt_reg == 3'd2)
                    begin
                        cnt_next = '0;
                        unique case (phase_reg)
                            PH_DIST:  state_next = S_SUBV;
                            PH_FORCE: state_next = S_G_MUL;
                            default:  state_next = S_UPD_END;
                        endcase
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + 3'd1;
                        state_next = S_SC_MUL;
                    end
                end
            end

            // Desired minus velocity, then clamp pass on the force
            S_SUBV:
            begin
                for (int i = 0; i < 3; i++)
                    s_next[i] = sat33(33'(s_reg[i]) - 33'(vel_reg[i]));
                phase_next = PH_FORCE;
                sum_next   = '0;
                cnt_next   = '0;
                state_next = S_SQ;
            end

            S_G_MUL:
                state_next = S_G_WR;

            S_G_WR:
            begin
                s_next[cnt_reg[1:0]] = gained;
                if (cnt_reg == 3'd2)
                    state_next = S_ACC;
                else
                begin
                    cnt_next   = cnt_reg + 3'd1;
                    state_next = S_G_MUL;
                end
            end

            S_ACC:
            begin
                for (int i = 0; i < 3; i++)
                    acc_next[i] = sat33(33'(acc_reg[i]) + 33'(s_reg[i]));
                state_next = S_OUT;
            end

            S_UPD_END:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    vel_next[i] = s_reg[i];
                    pos_next[i] = sat33(33'(pos_reg[i]) + 33'(s_reg[i]));
                    acc_next[i] = '0;
                    s_next[i]   = '0;
                end
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next.pos_x   = pos_reg[0];
                    out_next.pos_y   = pos_reg[1];
                    out_next.pos_z   = pos_reg[2];
                    out_next.vel_x   = vel_reg[0];
                    out_next.vel_y   = vel_reg[1];
                    out_next.vel_z   = vel_reg[2];
                    out_next.steer_x = s_reg[0];
                    out_next.steer_y = s_reg[1];
                    out_next.steer_z = s_reg[2];
                    out_valid_next   = 1'b1;
                    state_next       = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    // Unit requests
    assign div_req.start     = (state_reg == S_SC_GO);
    assign div_req.dividend  = prod_reg;
    assign div_req.divisor   = den_reg;
    assign sqrt_req.start    = (state_reg == S_SQRT_GO);
    assign sqrt_req.radicand = sum_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Checks
    `BSI_ASSERT_NEXT(a_accept_leaves_idle, in_valid && in_ready, state_reg != S_IDLE)
    `BSI_ASSERT_NOW(a_out_from_seq, out_valid && !$past(out_valid), $past(state_reg == S_OUT))
    `BSI_ASSERT_NEXT(a_upd_clears_acc, state_reg == S_UPD_END, acc_reg[0] == 0 && acc_reg[1] == 0 && acc_reg[2] == 0)
    `BSI_ASSERT_NOW(a_units_exclusive, sqrt_rsp.busy, !div_rsp.busy)

endmodule

// ===== design/bsi_div.sv =====
// Restoring divider, one quotient bit per cycle, 64-bit by 32-bit unsigned.
// Depends on bsi_pkg (request and response types).
module bsi_div (
    input  logic              clk,
    input  logic              rst_n,
    input  bsi_pkg::div_req_t req,
    output bsi_pkg::div_rsp_t rsp
);
    import bsi_pkg::*;

    logic        busy_reg, busy_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] quo_reg, quo_next;
    logic [31:0] den_reg, den_next;
    logic [31:0] rem_reg, rem_next;
    logic [32:0] shifted;
    logic [32:0] trial;

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    // One shift-subtract step per cycle
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[63]};
        trial     = shifted - {1'b0, den_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = req.dividend;
            den_next  = req.divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[31:0];
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
                busy_next = 1'b0;
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.quot = quo_reg;

endmodule

// ===== design/bsi_sqrt.sv =====
// Floor integer square root of a 64-bit value, one result bit per cycle.
// Depends on bsi_pkg (request and response types).
module bsi_sqrt (
    input  logic               clk,
    input  logic               rst_n,
    input  bsi_pkg::sqrt_req_t req,
    output bsi_pkg::sqrt_rsp_t rsp
);
    import bsi_pkg::*;

    logic        busy_reg, busy_next;
    logic [63:0] x_reg, x_next;
    logic [63:0] r_reg, r_next;
    logic [63:0] b_reg, b_next;
    logic [64:0] rb;

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        r_reg <= r_next;
        b_reg <= b_next;
    end

    // Bit-pair step: b walks down from 2^62 to 1
    always_comb
    begin
        rb        = {1'b0, r_reg} + {1'b0, b_reg};
        busy_next = busy_reg;
        x_next    = x_reg;
        r_next    = r_reg;
        b_next    = b_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            x_next    = req.radicand;
            r_next    = '0;
            b_next    = 64'h4000_0000_0000_0000;
        end
        else if (busy_reg)
        begin
            if ({1'b0, x_reg} >= rb)
            begin
                x_next = x_reg - rb[63:0];
                r_next = (r_reg >> 1) + b_reg;
            end
            else
                r_next = r_reg >> 1;
            b_next = b_reg >> 2;
            if (b_reg[0])
                busy_next = 1'b0;
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.root = r_reg[31:0];

endmodule

// ===== verif/boid_steering_integrator_tb.sv =====
// Self-checking testbench for boid_steering_integrator: directed and random commands,
// config phases, random idling on both channels. Depends on bsi_pkg and the block RTL.
`default_nettype none

module boid_steering_integrator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bsi_pkg::*;

    localparam int          LIMIT_CYCLES = 4000000;
    localparam int          HOLD_CYCLES  = 3000;
    localparam int          DRAIN_CYCLES = 40;
    localparam logic [1:0]  REG_HOLE     = 2'd2;
    localparam logic [1:0]  REG_SPARE    = 2'd3;
    localparam logic [2:0]  OP_BAD_LO    = 3'd5;
    localparam logic [2:0]  OP_BAD_MID   = 3'd6;
    localparam logic [2:0]  OP_BAD_HI    = 3'd7;
    localparam logic [30:0] U31_MAX      = 31'h7FFF_FFFF;
    localparam longint      ONE          = 64'sd65536;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    in_valid = 1'b0;
    logic    in_ready;
    cmd_t    in_data = '0;
    logic    out_valid;
    logic    out_ready = 1'b0;
    result_t out_data;
    logic    cfg_valid = 1'b0;
    logic    cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [30:0] cfg_data = '0;

    boid_steering_integrator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Agent mirror
    longint     agent_pos[3];
    longint     agent_vel[3];
    longint     agent_acc[3];
    bit [63:0]  speed_lim;
    bit [63:0]  force_lim;

    cmd_t       cmd_pending[$];
    result_t    agent_expected[$];
    int         errors = 0;
    int         cycles = 0;
    bit         calm = 1'b0;
    int         hold_asks = 0;

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic bit [63:0] magn(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic bit [63:0] floor_root(bit [63:0] x);
        bit [63:0] r;
        bit [63:0] b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > x)
            b >>= 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic bit [63:0] len_sq(longint a, longint b, longint c);
        return magn(a) * magn(a) + magn(b) * magn(b) + magn(c) * magn(c);
    endfunction

    // v * num / den on magnitudes, toward zero, saturated
    function automatic longint rescale(longint v, bit [63:0] num, bit [63:0] den);
        bit [63:0] q;
        if (den == 0)
            return 0;
        q = (magn(v) * num) / den;
        if (q > 64'h8000_0000)
            q = 64'h8000_0000;
        return clip32((v < 0) ? -longint'(q) : longint'(q));
    endfunction

    // Apply one command to the mirror and return the result it should give
    function automatic result_t agent_step(cmd_t c);
        longint    d[3];
        longint    s[3];
        bit [63:0] dsq;
        bit [63:0] rsq;
        bit [63:0] ease;
        bit [63:0] ln;
        bit [63:0] vsq;
        bit        act;
        result_t   r;
        rsq = 64'(c.reach) * 64'(c.reach);
        ease = 0;
        for (int i = 0; i < 3; i++)
            s[i] = 0;
        d[0] = clip32(longint'(c.target_x) - agent_pos[0]);
        d[1] = clip32(longint'(c.target_y) - agent_pos[1]);
        d[2] = clip32(longint'(c.target_z) - agent_pos[2]);
        dsq = len_sq(d[0], d[1], d[2]);
        if (c.opcode == OP_UPDATE)
        begin
            for (int i = 0; i < 3; i++)
                agent_vel[i] = clip32(agent_vel[i] + agent_acc[i]);
            vsq = len_sq(agent_vel[0], agent_vel[1], agent_vel[2]);
            if (vsq >= speed_lim * speed_lim)
            begin
                ln = floor_root(vsq);
                for (int i = 0; i < 3; i++)
                    agent_vel[i] = rescale(agent_vel[i], speed_lim, ln);
            end
            for (int i = 0; i < 3; i++)
            begin
                agent_pos[i] = clip32(agent_pos[i] + agent_vel[i]);
                agent_acc[i] = 0;
            end
        end
        else if (c.opcode <= OP_FLEE)
        begin
            act = 1'b1;
            if (c.opcode == OP_SEEK_OUT && dsq < rsq)
                act = 1'b0;
            if (c.opcode == OP_ARRIVE)
                ease = 64'(c.reach);
            if (c.opcode == OP_FLEE)
            begin
                if (dsq > rsq)
                    act = 1'b0;
                ease = 64'(c.reach);
            end
            if (act)
            begin
                if (dsq <= DEAD_ZONE_SQ)
                begin
                    for (int i = 0; i < 3; i++)
                        s[i] = d[i];
                end
                else
                begin
                    // desired velocity, eased inside the ease distance
                    if (ease > 64'(ONE_FIX) && dsq < ease * ease)
                        ln = ease;
                    else
                        ln = floor_root(dsq);
                    for (int i = 0; i < 3; i++)
                        s[i] = clip32(rescale(d[i], speed_lim, ln) - agent_vel[i]);
                    vsq = len_sq(s[0], s[1], s[2]);
                    if (vsq > force_lim * force_lim)
                    begin
                        ln = floor_root(vsq);
                        for (int i = 0; i < 3; i++)
                            s[i] = rescale(s[i], force_lim, ln);
                    end
                end
                for (int i = 0; i < 3; i++)
                begin
                    s[i] = clip32((s[i] * longint'(c.gain)) / ONE);
                    if (c.opcode == OP_FLEE)
                        s[i] = clip32(-s[i]);
                    agent_acc[i] = clip32(agent_acc[i] + s[i]);
                end
            end
        end
        r.pos_x = 32'(agent_pos[0]);
        r.pos_y = 32'(agent_pos[1]);
        r.pos_z = 32'(agent_pos[2]);
        r.vel_x = 32'(agent_vel[0]);
        r.vel_y = 32'(agent_vel[1]);
        r.vel_z = 32'(agent_vel[2]);
        r.steer_x = 32'(s[0]);
        r.steer_y = 32'(s[1]);
        r.steer_z = 32'(s[2]);
        return r;
    endfunction

    // Command driver
    int in_idle = 0;
    always @(posedge clk or negedge rst_n)
    begin
        logic nxt_valid;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                agent_expected.push_back(agent_step(in_data));
            nxt_valid = in_valid && !in_ready;
            if (!nxt_valid)
            begin
                if (in_idle > 0)
                    in_idle <= in_idle - 1;
                else if (cmd_pending.size() > 0)
                begin
                    nxt_valid = 1'b1;
                    in_data <= cmd_pending.pop_front();
                    if (!calm && $urandom_range(0, 9) == 0)
                        in_idle <= $urandom_range(1, 19);
                end
            end
            in_valid <= nxt_valid;
        end
    end

    // Result monitor and receiver stalls
    string field_name[9] = '{"pos_x", "pos_y", "pos_z", "vel_x", "vel_y", "vel_z",
                             "steer_x", "steer_y", "steer_z"};
    int out_idle = 0;
    int hold_seen = 0;
    always @(posedge clk or negedge rst_n)
    begin
        result_t     want;
        logic [31:0] e;
        logic [31:0] a;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (agent_expected.size() == 0)
                begin
                    $display("%0t: unexpected result transaction %h", $time, out_data);
                    errors++;
                end
                else
                begin
                    want = agent_expected.pop_front();
                    for (int i = 0; i < 9; i++)
                    begin
                        e = want[287 - 32 * i -: 32];
                        a = out_data[287 - 32 * i -: 32];
                        if (e !== a)
                        begin
                            $display("%0t: %s expected %0d actual %0d", $time,
                                     field_name[i], $signed(e), $signed(a));
                            errors++;
                        end
                    end
                end
            end
            if (hold_asks != hold_seen)
            begin
                hold_seen <= hold_asks;
                out_idle <= HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else if (out_idle > 0)
            begin
                out_idle <= out_idle - 1;
                out_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                out_idle <= $urandom_range(0, 18);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("** boid_steering_integrator: FAILED **");
            $finish;
        end
    end

    function automatic cmd_t mk(logic [2:0] op, int x, int y, int z, int rch, int g);
        cmd_t c;
        c.opcode = op;
        c.target_x = x;
        c.target_y = y;
        c.target_z = z;
        c.reach = 31'(rch);
        c.gain = g;
        return c;
    endfunction

    function automatic int near_val();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return $urandom_range(0, 3) - 2;
            default: return int'($urandom_range(0, 1 << 23)) - (1 << 22);
        endcase
    endfunction

    function automatic cmd_t rand_cmd();
        cmd_t c;
        int   k;
        k = $urandom_range(0, 99);
        if (k < 35)
            c.opcode = OP_UPDATE;
        else if (k < 95)
            c.opcode = 3'($urandom_range(OP_SEEK, OP_FLEE));
        else
            c.opcode = 3'($urandom_range(OP_BAD_LO, OP_BAD_HI));
        c.target_x = near_val();
        c.target_y = near_val();
        c.target_z = near_val();
        case ($urandom_range(0, 5))
            0: c.reach = 31'($urandom);
            1: c.reach = 31'($urandom_range(0, 1 << 16));
            default: c.reach = 31'($urandom_range(0, 1 << 23));
        endcase
        case ($urandom_range(0, 5))
            0: c.gain = $urandom;
            default: c.gain = int'($urandom_range(0, 1 << 18)) - (1 << 17);
        endcase
        return c;
    endfunction

    task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [30:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_MAX_SPEED)
            speed_lim = 64'(val);
        else if (idx == REG_MAX_FORCE)
            force_lim = 64'(val);
        cfg_valid <= 1'b0;
    endtask

    // Sampled between edges so the driver's updates have settled
    task automatic settle();
        do
            @(negedge clk);
        while (cmd_pending.size() != 0 || in_valid || agent_expected.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_phase(int n);
        repeat (n) cmd_pending.push_back(rand_cmd());
        settle();
    endtask

    // Stimulus sequence
    initial
    begin
        for (int i = 0; i < 3; i++)
        begin
            agent_pos[i] = 0;
            agent_vel[i] = 0;
            agent_acc[i] = 0;
        end
        speed_lim = 64'(MAX_SPEED_RST);
        force_lim = 64'(MAX_FORCE_RST);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: dead zone, easing, skips, opcodes, field extremes
        cmd_pending.push_back(mk(OP_SEEK, 0, 0, 0, 0, 65536));
        cmd_pending.push_back(mk(OP_SEEK, 1, 0, 0, 0, 65536));
        cmd_pending.push_back(mk(OP_SEEK, 10 << 16, 0, 0, 0, 65536));
        cmd_pending.push_back(mk(OP_UPDATE, 0, 0, 0, 0, 0));
        cmd_pending.push_back(mk(OP_ARRIVE, 1 << 16, 2 << 16, 0, 20 << 16, 65536));
        cmd_pending.push_back(mk(OP_ARRIVE, 1 << 16, 0, 0, 1 << 16, 65536));
        cmd_pending.push_back(mk(OP_SEEK_OUT, 5 << 16, 0, 0, U31_MAX, 65536));
        cmd_pending.push_back(mk(OP_SEEK_OUT, 5 << 16, 0, 0, 0, -65536));
        cmd_pending.push_back(mk(OP_FLEE, 5 << 16, 5 << 16, 0, 0, 65536));
        cmd_pending.push_back(mk(OP_FLEE, 3 << 16, 0, 1 << 16, U31_MAX, 65536));
        cmd_pending.push_back(mk(OP_UPDATE, 0, 0, 0, 0, 0));
        cmd_pending.push_back(mk(OP_SEEK, 32'h7FFF_FFFF, 32'h8000_0000, -1, 0, 32'h7FFF_FFFF));
        cmd_pending.push_back(mk(OP_FLEE, 32'h8000_0000, 32'h7FFF_FFFF, 0, U31_MAX,
                                 32'h8000_0000));
        cmd_pending.push_back(mk(OP_BAD_LO, 1, 2, 3, 4, 5));
        cmd_pending.push_back(mk(OP_BAD_MID, -1, -1, -1, U31_MAX, -1));
        cmd_pending.push_back(mk(OP_BAD_HI, 0, 0, 0, 0, 0));
        cmd_pending.push_back(mk(OP_UPDATE, 0, 0, 0, 0, 0));
        settle();

        // extreme limits: saturating velocity and position
        reg_write(REG_MAX_SPEED, U31_MAX);
        reg_write(REG_MAX_FORCE, U31_MAX);
        reg_write(REG_SPARE, 31'd12345);
        reg_write(REG_HOLE, 31'd1);
        cmd_pending.push_back(mk(OP_SEEK, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0,
                                 32'h7FFF_FFFF));
        cmd_pending.push_back(mk(OP_FLEE, 0, 0, 0, U31_MAX, 32'h8000_0000));
        cmd_pending.push_back(mk(OP_UPDATE, 0, 0, 0, 0, 0));
        cmd_pending.push_back(mk(OP_UPDATE, 0, 0, 0, 0, 0));
        random_phase(120);

        // zero limits: velocity clamped to zero
        reg_write(REG_MAX_SPEED, 31'd0);
        reg_write(REG_MAX_FORCE, 31'd0);
        cmd_pending.push_back(mk(OP_UPDATE, 0, 0, 0, 0, 0));
        random_phase(80);

        // moderate limits, with a long receiver hold-off
        reg_write(REG_MAX_SPEED, 31'd131072);
        reg_write(REG_MAX_FORCE, 31'd20000);
        @(posedge clk);
        hold_asks <= hold_asks + 1;
        random_phase(250);

        reg_write(REG_MAX_SPEED, 31'($urandom_range(0, 1 << 22)));
        reg_write(REG_MAX_FORCE, 31'($urandom_range(0, 1 << 20)));
        random_phase(150);

        // final stretch with no idling
        reg_write(REG_MAX_SPEED, MAX_SPEED_RST);
        reg_write(REG_MAX_FORCE, MAX_FORCE_RST);
        @(posedge clk);
        calm <= 1'b1;
        random_phase(200);

        if (errors == 0)
            $display("** boid_steering_integrator: PASSED **");
        else
            $display("** boid_steering_integrator: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+design
design/bsi_pkg.sv
design/bsi_div.sv
design/bsi_sqrt.sv
design/boid_steering_integrator.sv
verif/boid_steering_integrator_tb.sv
